/* design/msgr_pkg.sv */
// shared constants and codes for the multi-stop gradient row colour block
package msgr_pkg;

  localparam int MAX_STOPS = 8;
  localparam int STOP_AW   = $clog2(MAX_STOPS);

  localparam int POS_W   = 7;
  localparam int COLOR_W = 32;
  localparam int STOP_W  = POS_W + COLOR_W;

  localparam int REM_W = 24;
  localparam int DSH_W = 25;

  localparam logic [1:0] CMD_STOP    = 2'd0;
  localparam logic [1:0] CMD_RESTART = 2'd1;
  localparam logic [1:0] CMD_ROW     = 2'd2;

  localparam logic [1:0] REG_TOP    = 2'd0;
  localparam logic [1:0] REG_BOTTOM = 2'd1;
  localparam logic [1:0] REG_COUNT  = 2'd2;

  localparam logic [8:0] POS_FULL  = 9'd256;
  localparam logic [6:0] PCT_SCALE = 7'd100;

endpackage

/* design/msgr_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
module msgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/multi_stop_gradient_row_color_core.sv */
// Colour of one row of a vertical multi-stop gradient. Stops sit in a small
// ram of packed position and colour; stop writes and walk restarts are taken
// in the idle state. A row item holds the input off while it runs: one setup
// step, a restoring divider of ten steps for the row position (one step when
// the quotient clamps to full, none when the position is fixed at once), a step
// to scale it to percent, a ram read and a check of the current stop (a fresh
// read and check when the walk restarts at stop zero), one check per further
// stop visited (up to seven, registered read), eight more divider steps for
// the position inside the segment and one lerp step. The lerp step waits while
// an earlier colour is still held by the receiver. New items are held off
// until the row is finished, while a finished colour waits in the output
// register without blocking the next stop write.
module multi_stop_gradient_row_color_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [2:0]  in_stop_slot,
  input  logic [6:0]  in_stop_position,
  input  logic [31:0] in_stop_color,
  input  logic signed [15:0] in_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [2:0]  out_segment,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_DIV, S_PCT, S_RD_I, S_CHK_I, S_CHK_N, S_LERP
  } state_t;

  localparam int AW = msgr_pkg::STOP_AW;

  state_t state_r;

  logic signed [15:0] top_r, bottom_r;
  logic [3:0]         count_r;
  logic [AW-1:0]      walk_r;

  logic signed [15:0] row_r;
  logic [8:0]         pos_r;
  logic [6:0]         pct_r;
  logic [AW-1:0]      i_r;
  logic [6:0]         p_i_r;
  logic [31:0]        c0_r, c1_r;
  logic [7:0]         r_r;

  logic [msgr_pkg::REM_W-1:0] rem_r;
  logic [msgr_pkg::DSH_W-1:0] dsh_r;
  logic [8:0]                 q_r;
  logic [3:0]                 cnt_r;
  logic                       sat_chk_r;
  logic                       div_pos_r;

  logic        out_valid_r;
  logic [7:0]  red_r, green_r, blue_r, alpha_r;
  logic [AW-1:0] seg_r;

  // ram access
  logic                        ram_we;
  logic [AW-1:0]               ram_raddr;
  logic [msgr_pkg::STOP_W-1:0] ram_rdata;
  logic [6:0]                  rd_pos;
  logic [31:0]                 rd_color;

  logic        in_acc;
  logic [AW-1:0] last;
  logic signed [16:0] diff, dden;
  logic [15:0] diff_mag, dden_mag;
  logic [25:0] trial;
  logic        ge;
  logic [8:0]  q_nxt;
  logic [15:0] pct_prod;
  logic [AW-1:0] i_inc;
  logic [7:0]  lerp_nxt [4];

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign ram_we   = in_acc && (in_command == msgr_pkg::CMD_STOP);
  assign rd_pos   = ram_rdata[msgr_pkg::STOP_W-1:msgr_pkg::COLOR_W];
  assign rd_color = ram_rdata[msgr_pkg::COLOR_W-1:0];
  assign i_inc    = i_r + AW'(1);

  msgr_ram #(
    .WIDTH(msgr_pkg::STOP_W),
    .DEPTH(msgr_pkg::MAX_STOPS)
  ) u_stops (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(in_stop_slot)),
    .wdata({in_stop_position, in_stop_color}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    case (state_r)
      S_CHK_I: ram_raddr = i_inc;
      S_CHK_N: ram_raddr = i_r + AW'(2);
      default: ram_raddr = i_r;
    endcase
  end

  // last usable stop index from the clamped stop count
  always_comb begin
    if (count_r < 4'd2) begin
      last = AW'(1);
    end else if (32'(count_r) > msgr_pkg::MAX_STOPS) begin
      last = AW'(msgr_pkg::MAX_STOPS - 1);
    end else begin
      last = AW'(count_r - 4'd1);
    end
  end

  always_comb begin
    diff     = 17'(row_r) - 17'(top_r);
    dden     = 17'(bottom_r) - 17'(top_r);
    diff_mag = diff[16] ? 16'(-diff) : diff[15:0];
    dden_mag = dden[16] ? 16'(-dden) : dden[15:0];
    trial    = {2'b00, rem_r} - {1'b0, dsh_r};
    ge       = !trial[25];
    q_nxt    = {q_r[7:0], ge};
    pct_prod = 16'(pos_r) * 16'(msgr_pkg::PCT_SCALE);
  end

  always_comb begin
    logic [16:0] sum;
    logic [8:0]  w0;
    sum = '0;
    w0  = msgr_pkg::POS_FULL - {1'b0, r_r};
    for (int ch = 0; ch < 4; ch++) begin
      sum = 17'(c0_r[8*ch +: 8]) * 17'(w0) + 17'(c1_r[8*ch +: 8]) * 17'(r_r);
      lerp_nxt[ch] = sum[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= 16'sd0;
      bottom_r    <= 16'sd255;
      count_r     <= 4'd2;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          msgr_pkg::REG_TOP:    top_r    <= cfg_data;
          msgr_pkg::REG_BOTTOM: bottom_r <= cfg_data;
          msgr_pkg::REG_COUNT:  count_r  <= cfg_data[3:0];
          default: ;
        endcase
      end
      // the lerp step reloads the output register itself
      if (out_valid_r && !out_stall && state_r != S_LERP) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_command)
              msgr_pkg::CMD_RESTART: walk_r <= '0;
              msgr_pkg::CMD_ROW: begin
                row_r   <= in_row;
                state_r <= S_SETUP;
              end
              default: ;
            endcase
          end
        end
        S_SETUP: begin
          if (dden == 17'sd0) begin
            pos_r   <= msgr_pkg::POS_FULL;
            state_r <= S_PCT;
          end else if (diff == 17'sd0 || diff[16] != dden[16]) begin
            pos_r   <= '0;
            state_r <= S_PCT;
          end else begin
            rem_r     <= {diff_mag, 8'd0};
            dsh_r     <= {dden_mag, 9'd0};
            q_r       <= '0;
            cnt_r     <= 4'd8;
            sat_chk_r <= 1'b1;
            div_pos_r <= 1'b1;
            state_r   <= S_DIV;
          end
        end
        S_DIV: begin
          dsh_r <= dsh_r >> 1;
          if (sat_chk_r) begin
            // quotient of 512 or more clamps straight to full
            if (ge) begin
              pos_r   <= msgr_pkg::POS_FULL;
              state_r <= S_PCT;
            end
            sat_chk_r <= 1'b0;
          end else begin
            if (ge) begin
              rem_r <= trial[msgr_pkg::REM_W-1:0];
            end
            q_r   <= q_nxt;
            cnt_r <= cnt_r - 4'd1;
            if (cnt_r == 4'd0) begin
              if (div_pos_r) begin
                pos_r   <= (q_nxt > msgr_pkg::POS_FULL) ? msgr_pkg::POS_FULL : q_nxt;
                state_r <= S_PCT;
              end else begin
                r_r     <= q_nxt[7:0];
                state_r <= S_LERP;
              end
            end
          end
        end
        S_PCT: begin
          pct_r   <= pct_prod[14:8];
          i_r     <= (walk_r > last) ? '0 : walk_r;
          state_r <= S_RD_I;
        end
        S_RD_I: begin
          state_r <= S_CHK_I;
        end
        S_CHK_I: begin
          if (pct_r < rd_pos && i_r != '0) begin
            // behind the current stop: walk again from stop zero
            i_r     <= '0;
            state_r <= S_RD_I;
          end else begin
            p_i_r <= rd_pos;
            c0_r  <= rd_color;
            if (i_r == last) begin
              c1_r    <= rd_color;
              r_r     <= '0;
              state_r <= S_LERP;
            end else begin
              state_r <= S_CHK_N;
            end
          end
        end
        S_CHK_N: begin
          if (pct_r >= rd_pos) begin
            i_r   <= i_inc;
            p_i_r <= rd_pos;
            c0_r  <= rd_color;
            if (i_inc == last) begin
              c1_r    <= rd_color;
              r_r     <= '0;
              state_r <= S_LERP;
            end
          end else begin
            c1_r <= rd_color;
            if (pct_r < p_i_r) begin
              r_r     <= '0;
              state_r <= S_LERP;
            end else begin
              rem_r     <= {9'd0, 7'(pct_r - p_i_r), 8'd0};
              dsh_r     <= {11'd0, 7'(rd_pos - p_i_r), 7'd0};
              q_r       <= '0;
              cnt_r     <= 4'd7;
              sat_chk_r <= 1'b0;
              div_pos_r <= 1'b0;
              state_r   <= S_DIV;
            end
          end
        end
        S_LERP: begin
          if (!(out_valid_r && out_stall)) begin
            red_r       <= lerp_nxt[0];
            green_r     <= lerp_nxt[1];
            blue_r      <= lerp_nxt[2];
            alpha_r     <= lerp_nxt[3];
            seg_r       <= i_r;
            walk_r      <= i_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_red     = red_r;
  assign out_green   = green_r;
  assign out_blue    = blue_r;
  assign out_alpha   = alpha_r;
  assign out_segment = 3'(seg_r);

  a_row_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_command == msgr_pkg::CMD_ROW |=> state_r == S_SETUP)
    else $error("row item did not start the position setup");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> dsh_r != '0)
    else $error("divider running with a zero divisor");

  a_result_from_lerp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_LERP)
    else $error("result raised outside the lerp step");

endmodule

/* dv/multi_stop_gradient_row_color_core_tb.sv */
// self-checking testbench for the multi-stop gradient row colour core
module multi_stop_gradient_row_color_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_LEN       = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int PHASE_ITEMS    = 43;

  typedef struct {
    logic [1:0]         command;
    logic [2:0]         slot;
    logic [6:0]         position;
    logic [31:0]        color;
    logic signed [15:0] row;
  } gradient_item_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [2:0] segment;
  } row_colour_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_command = msgr_pkg::CMD_STOP;
  logic [2:0]         in_stop_slot = '0;
  logic [6:0]         in_stop_position = '0;
  logic [31:0]        in_stop_color = '0;
  logic signed [15:0] in_row = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_red;
  logic [7:0]         out_green;
  logic [7:0]         out_blue;
  logic [7:0]         out_alpha;
  logic [2:0]         out_segment;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = msgr_pkg::REG_TOP;
  logic [15:0]        cfg_data = '0;

  // mirror of the block's stop table, walk and registers
  logic [6:0]         stop_pos_tbl [msgr_pkg::MAX_STOPS];
  logic [31:0]        stop_rgba_tbl [msgr_pkg::MAX_STOPS];
  logic [2:0]         walk_at = '0;
  logic signed [15:0] top_row = 16'sd0;
  logic signed [15:0] bottom_row = 16'sd255;
  logic [3:0]         stop_cnt = 4'd2;

  gradient_item_t cmd_q [$];
  row_colour_t    colour_q [$];

  int   queued_n = 0;
  int   accepted_n = 0;
  int   err_cnt = 0;
  int   idle_cycles = 0;
  int   send_gap = 0;
  int   stall_left = 0;
  int   hold_cnt = 0;
  int   idle_rate = 0;
  logic hold_on = 1'b0;
  logic in_took = 1'b0;

  multi_stop_gradient_row_color_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_stop_slot     (in_stop_slot),
    .in_stop_position (in_stop_position),
    .in_stop_color    (in_stop_color),
    .in_row           (in_row),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_segment      (out_segment),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int stops_in_use();
    int n;
    n = stop_cnt;
    if (n < 2) n = 2;
    if (n > msgr_pkg::MAX_STOPS) n = msgr_pkg::MAX_STOPS;
    return n;
  endfunction

  function automatic logic [7:0] lerp8(logic [7:0] a, logic [7:0] b, int w);
    int v;
    v = (int'(a) * (int'(msgr_pkg::POS_FULL) - w) + int'(b) * w) >> 8;
    return v[7:0];
  endfunction

  // colour of one row; moves the walk index on as the block does
  function automatic row_colour_t shade_row(logic signed [15:0] r);
    int          n, pct, i, inner;
    longint      den, num, pos;
    logic [31:0] c0, c1;
    row_colour_t res;
    n = stops_in_use();
    den = longint'(bottom_row) - longint'(top_row);
    if (den == 0) begin
      pos = 256;
    end else begin
      num = (longint'(r) - longint'(top_row)) * 256;
      pos = num / den;
      if (pos < 0) pos = 0;
      if (pos > 256) pos = 256;
    end
    pct = int'((pos * int'(msgr_pkg::PCT_SCALE)) >> 8);
    i = walk_at;
    // walk restarts when out of range or when the row lies behind the current stop
    if (i >= n || pct < int'(stop_pos_tbl[i])) i = 0;
    while (i < n - 1 && pct >= int'(stop_pos_tbl[i + 1])) i++;
    walk_at = i[2:0];
    c0 = stop_rgba_tbl[i];
    if (i >= n - 1) begin
      c1 = c0;
      inner = 0;
    end else begin
      c1 = stop_rgba_tbl[i + 1];
      if (pct < int'(stop_pos_tbl[i])) inner = 0;
      else inner = ((pct - int'(stop_pos_tbl[i])) * 256) /
                   (int'(stop_pos_tbl[i + 1]) - int'(stop_pos_tbl[i]));
      if (inner > 256) inner = 256;
    end
    res.red     = lerp8(c0[7:0], c1[7:0], inner);
    res.green   = lerp8(c0[15:8], c1[15:8], inner);
    res.blue    = lerp8(c0[23:16], c1[23:16], inner);
    res.alpha   = lerp8(c0[31:24], c1[31:24], inner);
    res.segment = i[2:0];
    return res;
  endfunction

  task automatic apply_item(gradient_item_t it);
    case (it.command)
      msgr_pkg::CMD_STOP: begin
        stop_pos_tbl[it.slot]  = it.position;
        stop_rgba_tbl[it.slot] = it.color;
      end
      msgr_pkg::CMD_RESTART: walk_at = '0;
      msgr_pkg::CMD_ROW:     colour_q.push_back(shade_row(it.row));
      default: ;
    endcase
  endtask

  task automatic flag_error(string what, int got, int want);
    err_cnt++;
    if (err_cnt <= 100)
      $display("mismatch: %s got %0d expected %0d", what, got, want);
  endtask

  // results, item acceptance and the watchdog
  always @(posedge clk) begin
    gradient_item_t it;
    row_colour_t    want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (colour_q.size() == 0) begin
          flag_error("colour with no row pending, segment", out_segment, 0);
        end else begin
          want = colour_q.pop_front();
          if (out_red !== want.red) flag_error("red", out_red, want.red);
          if (out_green !== want.green) flag_error("green", out_green, want.green);
          if (out_blue !== want.blue) flag_error("blue", out_blue, want.blue);
          if (out_alpha !== want.alpha) flag_error("alpha", out_alpha, want.alpha);
          if (out_segment !== want.segment)
            flag_error("segment", out_segment, want.segment);
        end
      end
      if (in_valid && !in_stall) begin
        it.command  = in_command;
        it.slot     = in_stop_slot;
        it.position = in_stop_position;
        it.color    = in_stop_color;
        it.row      = in_row;
        apply_item(it);
        accepted_n <= accepted_n + 1;
      end
      in_took <= in_valid && !in_stall;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // sender
  always @(negedge clk) begin
    gradient_item_t nxt;
    if (rst_n && (!in_valid || in_took)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (cmd_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_rate) begin
        send_gap <= $urandom_range(0, 4);
        in_valid <= 1'b0;
      end else begin
        nxt = cmd_q.pop_front();
        in_valid         <= 1'b1;
        in_command       <= nxt.command;
        in_stop_slot     <= nxt.slot;
        in_stop_position <= nxt.position;
        in_stop_color    <= nxt.color;
        in_row           <= nxt.row;
      end
    end
  end

  // receiver: one long hold on request, otherwise short random stalls
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_on && hold_cnt < HOLD_LEN) begin
        out_stall <= 1'b1;
        hold_cnt  <= hold_cnt + 1;
      end else if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < idle_rate) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 4);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_item(logic [1:0] cmd, int slot, int p, logic [31:0] c, int r);
    gradient_item_t it;
    if (r < -32768) r = -32768;
    if (r > 32767) r = 32767;
    it.command  = cmd;
    it.slot     = slot[2:0];
    it.position = p[6:0];
    it.color    = c;
    it.row      = r[15:0];
    cmd_q.push_back(it);
    queued_n++;
  endtask

  function automatic logic [31:0] pick_colour();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic int any_row();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic settle();
    do @(negedge clk); while (accepted_n != queued_n || colour_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_gradient(int t, int b, logic [3:0] cnt);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= msgr_pkg::REG_TOP;
    cfg_data  <= t[15:0];
    @(negedge clk);
    cfg_index <= msgr_pkg::REG_BOTTOM;
    cfg_data  <= b[15:0];
    @(negedge clk);
    cfg_index <= msgr_pkg::REG_COUNT;
    cfg_data  <= {12'($urandom), cnt};
    @(negedge clk);
    cfg_we     <= 1'b0;
    top_row    = t[15:0];
    bottom_row = b[15:0];
    stop_cnt   = cnt;
  endtask

  // mostly a fresh ascending stop set, a restart and rows walking down the gradient
  task automatic fill_phase(int n_items);
    int target, n, p, m, f, span, k, j;
    target = queued_n + n_items;
    while (queued_n < target) begin
      k = $urandom_range(0, 9);
      if (k < 6) begin
        n = stops_in_use();
        p = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 20) : 0;
        for (j = 0; j < n; j++) begin
          if (j == n - 1) p = ($urandom_range(0, 3) == 0) ? $urandom_range(p, 100) : 100;
          else if (j > 0) p = p + $urandom_range(0, 200 / (n - 1));
          if (p > 100) p = 100;
          push_item(msgr_pkg::CMD_STOP, j, p, pick_colour(), any_row());
        end
        push_item(msgr_pkg::CMD_RESTART, $urandom_range(0, 7), $urandom_range(0, 127),
                  $urandom, any_row());
        m = $urandom_range(3, 8);
        span = int'(bottom_row) - int'(top_row);
        f = int'($urandom_range(0, 30)) - 15;
        for (j = 0; j < m; j++) begin
          push_item(msgr_pkg::CMD_ROW, $urandom_range(0, 7), $urandom_range(0, 127),
                    $urandom, int'(top_row) + span * f / 100);
          f += $urandom_range(0, 25);
        end
      end else if (k < 8) begin
        push_item(msgr_pkg::CMD_STOP, $urandom_range(0, 7), $urandom_range(0, 100),
                  pick_colour(), any_row());
      end else if (k == 8) begin
        push_item(msgr_pkg::CMD_ROW, $urandom_range(0, 7), $urandom_range(0, 127),
                  $urandom, any_row());
      end else begin
        push_item($urandom_range(0, 1) ? msgr_pkg::CMD_RESTART : CMD_UNUSED,
                  $urandom_range(0, 7), $urandom_range(0, 127), $urandom, any_row());
      end
    end
  endtask

  task automatic run_phase(int t, int b, logic [3:0] cnt, int rate);
    settle();
    set_gradient(t, b, cnt);
    idle_rate = rate;
    fill_phase(PHASE_ITEMS);
  endtask

  initial begin
    int ph, t, b, j;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // reset registers: two stops, stop 0 starting at a quarter
    idle_rate = 15;
    push_item(msgr_pkg::CMD_STOP, 0, 25, 32'hFFFF_FFFF, 0);
    push_item(msgr_pkg::CMD_STOP, 1, 100, 32'h0000_0000, -1);
    for (j = 2; j < msgr_pkg::MAX_STOPS; j++)
      push_item(msgr_pkg::CMD_STOP, j, 100, $urandom, any_row());
    push_item(msgr_pkg::CMD_ROW, 0, 0, 0, -32768);
    push_item(msgr_pkg::CMD_ROW, 7, 127, 32'hFFFF_FFFF, 0);
    push_item(msgr_pkg::CMD_ROW, 0, 0, 0, 64);
    push_item(msgr_pkg::CMD_ROW, 0, 0, 0, 128);
    push_item(msgr_pkg::CMD_ROW, 0, 0, 0, 254);
    push_item(msgr_pkg::CMD_ROW, 0, 0, 0, 255);
    push_item(msgr_pkg::CMD_ROW, 0, 0, 0, 32767);
    // row behind the current stop
    push_item(msgr_pkg::CMD_ROW, 0, 0, 0, 10);
    push_item(msgr_pkg::CMD_RESTART, 5, 64, 32'hA5A5_5A5A, 12345);
    push_item(CMD_UNUSED, 2, 99, 32'h1234_5678, -12345);
    push_item(msgr_pkg::CMD_ROW, 0, 0, 0, 200);

    run_phase(0, 255, 4'd8, 20);
    run_phase(-32768, 32767, 4'd2, 10);
    // bottom above top, and the receiver holding off while rows keep coming
    hold_on = 1'b1;
    run_phase(32767, -32768, 4'd5, 10);
    run_phase(100, 100, 4'd3, 30);
    run_phase(-50, 300, 4'd0, 0);
    run_phase(0, 1, 4'd15, 20);
    for (ph = 0; ph < 3; ph++) begin
      t = int'($urandom_range(0, 800)) - 400;
      b = t + int'($urandom_range(0, 800)) - 400;
      run_phase(t, b, 4'($urandom_range(2, 8)), 5 + 10 * ph);
    end
    t = int'($urandom_range(0, 800)) - 400;
    run_phase(t, t + int'($urandom_range(1, 600)), 4'($urandom_range(2, 8)), 0);
    settle();

    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
